// ===== rtl/core/bba_pkg.sv =====
// Package of shared types, constants and helper functions for the buddy block allocator.
`default_nettype none
package bba_pkg;

   localparam int TOP_ORDER = 10;
   localparam int ORDER_COUNT = TOP_ORDER + 1;
   localparam int ORDER_W = 4;
   localparam int UNIT_W = 15;
   localparam int USED_W = 4;
   localparam int MAP_ADDR_W = 11;
   localparam int MAP_WORDS = 2047;
   localparam int MAP_WORD_W = 32;
   localparam int SCAN_W = 10;

   localparam logic [MAP_ADDR_W-1:0] TOP_WORD_ADDR = 11'd2046;
   localparam logic [UNIT_W-1:0] CLEAR_LAST = 15'd32767;
   localparam logic [26:0] SIZE_LIMIT = 27'd100000000;
   localparam logic [27:0] TOP_BYTES = 28'd131072;
   localparam logic [6:0] HEADER_AT_RESET = 7'd32;
   localparam logic [15:0] BLOCKS_AT_RESET = 16'd32;
   localparam logic [22:0] PAYLOAD_AT_RESET = 23'd4193280;

   localparam logic [0:0] KIND_ALLOC = 1'b0;
   localparam logic [0:0] KIND_FREE = 1'b1;

   localparam logic [1:0] STATUS_DONE = 2'd0;
   localparam logic [1:0] STATUS_REFUSED = 2'd1;
   localparam logic [1:0] STATUS_NO_BLOCK = 2'd2;
   localparam logic [1:0] STATUS_IGNORED = 2'd3;

   typedef struct packed {
      logic [0:0] kind;
      logic [26:0] request_size;
      logic [21:0] payload_offset;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [21:0] granted_offset;
      logic [15:0] free_block_count;
      logic [22:0] free_payload_bytes;
      logic [15:0] total_block_count;
      logic [22:0] total_payload_bytes;
   } rsp_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_SPLIT_RD,
      S_SPLIT_WR,
      S_ALLOC_END,
      S_USED_RD,
      S_USED_CK,
      S_MERGE_RD,
      S_MERGE_CK,
      S_RESP
   } state_type;

   function automatic logic [MAP_ADDR_W-1:0] word_base(input logic [ORDER_W-1:0] k);
      logic [MAP_ADDR_W:0] full;
      full = 12'd2048 - (12'd1 << (5'd11 - {1'b0, k}));
      return full[MAP_ADDR_W-1:0];
   endfunction

   function automatic logic [22:0] block_payload(input logic [ORDER_W-1:0] k,
                                                 input logic [6:0] hdr);
      logic [22:0] bytes;
      bytes = 23'd128 << k;
      return bytes - {16'd0, hdr};
   endfunction

   function automatic logic [4:0] lowest_set(input logic [MAP_WORD_W-1:0] d);
      logic [4:0] r;
      r = 5'd0;
      for (int i = MAP_WORD_W - 1; i >= 0; i--) begin
         if (d[i]) begin
            r = 5'(i);
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/buddy_block_allocator_core.sv =====
// Top level of the buddy block allocator: control sequencer around the free bitmap and used table.
// After reset the block runs a clearing pass over its tables before it takes its first
// request; header writes are taken throughout. The free bitmap is one RAM of 32-bit words,
// one word read and one written per cycle; allocations and frees that go ahead walk it order
// by order. An allocation scans the bitmap words of the chosen order one after another (up to
// 1024 words at the smallest order, 32 blocks per word), then splits down one order at a time.
// A free checks the used table, then merges with its buddy order by order while the buddy is
// free. Refused requests and ignored frees skip the scan and the merge. A new request is
// taken while the previous result still waits for its transfer.
`default_nettype none
module buddy_block_allocator_core (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire bba_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output bba_pkg::rsp_type     rsp_data,
   input  wire logic            csr_wr_en,
   input  wire logic [6:0]      csr_wr_data
);

   bba_pkg::state_type state_ff, state_in;
   logic [bba_pkg::UNIT_W-1:0] clr_ff, clr_in;
   bba_pkg::req_type req_ff, req_in;
   logic [6:0] hdr_ff;
   logic [bba_pkg::ORDER_W-1:0] ord_ff, ord_in, k_ff, k_in;
   logic [bba_pkg::UNIT_W-1:0] idx_ff, idx_in, u_ff, u_in;
   logic [bba_pkg::SCAN_W-1:0] scan_ff, scan_in;
   logic scan_vld_ff, scan_vld_in;
   logic [1:0] status_ff, status_in;
   logic [21:0] granted_ff, granted_in;
   logic [15:0] free_blk_ff, free_blk_in, blk_ff, blk_in;
   logic [22:0] free_pay_ff, free_pay_in, pay_ff, pay_in;
   logic [15:0] cnt_ff [0:bba_pkg::ORDER_COUNT-1];
   logic [15:0] cnt_in [0:bba_pkg::ORDER_COUNT-1];
   logic rsp_valid_ff, rsp_valid_in;
   bba_pkg::rsp_type rsp_ff, rsp_in;

   logic map_we;
   logic [bba_pkg::MAP_ADDR_W-1:0] map_waddr, map_raddr;
   logic [bba_pkg::MAP_WORD_W-1:0] map_wdata, map_rdata;
   logic used_we;
   logic [bba_pkg::UNIT_W-1:0] used_waddr, used_raddr;
   logic [bba_pkg::USED_W-1:0] used_wdata, used_rdata;

   logic [27:0] eff;
   logic dec_refuse, dec_none;
   logic [bba_pkg::ORDER_W-1:0] dec_ord, dec_kf;
   logic [21:0] free_s;
   logic free_bad;
   logic scan_hit;
   logic [bba_pkg::SCAN_W-1:0] scan_wi;
   logic [4:0] scan_bit;
   logic [bba_pkg::UNIT_W-1:0] split_j;
   logic used_bad;
   logic merge_go;
   logic rsp_free;
   logic [22:0] k_pay;

   bba_ram #(
      .DATA_W(bba_pkg::MAP_WORD_W),
      .ADDR_W(bba_pkg::MAP_ADDR_W)
   ) u_free_map (
      .clock(clock),
      .we(map_we),
      .waddr(map_waddr),
      .wdata(map_wdata),
      .raddr(map_raddr),
      .rdata(map_rdata)
   );

   bba_ram #(
      .DATA_W(bba_pkg::USED_W),
      .ADDR_W(bba_pkg::UNIT_W)
   ) u_used_table (
      .clock(clock),
      .we(used_we),
      .waddr(used_waddr),
      .wdata(used_wdata),
      .raddr(used_raddr),
      .rdata(used_rdata)
   );

   always_comb begin
      eff = {1'b0, req_ff.request_size} + {21'd0, hdr_ff};
      dec_refuse = (req_ff.request_size == 27'd0) || (req_ff.request_size > bba_pkg::SIZE_LIMIT)
                   || (eff > bba_pkg::TOP_BYTES);
      dec_ord = 4'(bba_pkg::TOP_ORDER);
      for (int k = bba_pkg::TOP_ORDER; k >= 0; k--) begin
         if ((28'd128 << k) >= eff) begin
            dec_ord = 4'(k);
         end
      end
      dec_none = 1'b1;
      dec_kf = 4'(bba_pkg::TOP_ORDER);
      for (int k = bba_pkg::TOP_ORDER; k >= 0; k--) begin
         if ((4'(k) >= dec_ord) && (cnt_ff[k] != 16'd0)) begin
            dec_none = 1'b0;
            dec_kf = 4'(k);
         end
      end
      free_s = req_ff.payload_offset - {15'd0, hdr_ff};
      free_bad = (req_ff.payload_offset < {15'd0, hdr_ff}) || (free_s[6:0] != 7'd0);
      scan_hit = scan_vld_ff && (map_rdata != '0);
      scan_wi = scan_ff - 10'd1;
      scan_bit = bba_pkg::lowest_set(map_rdata);
      split_j = (u_ff >> k_ff) | 15'd1;
      used_bad = (used_rdata == 4'd0) || (used_rdata > 4'(bba_pkg::ORDER_COUNT));
      merge_go = (k_ff < 4'(bba_pkg::TOP_ORDER)) && map_rdata[idx_ff[4:0] ^ 5'd1];
      rsp_free = !rsp_valid_ff || !rsp_stall;
      k_pay = bba_pkg::block_payload(k_ff, hdr_ff);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bba_pkg::S_CLEAR: begin
            if (clr_ff == bba_pkg::CLEAR_LAST) begin
               state_in = bba_pkg::S_IDLE;
            end
         end
         bba_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = bba_pkg::S_DECODE;
            end
         end
         bba_pkg::S_DECODE: begin
            if (req_ff.kind == bba_pkg::KIND_ALLOC) begin
               state_in = (dec_refuse || dec_none) ? bba_pkg::S_RESP : bba_pkg::S_SCAN;
            end else begin
               state_in = free_bad ? bba_pkg::S_RESP : bba_pkg::S_USED_RD;
            end
         end
         bba_pkg::S_SCAN: begin
            if (scan_hit) begin
               state_in = (k_ff > ord_ff) ? bba_pkg::S_SPLIT_RD : bba_pkg::S_ALLOC_END;
            end
         end
         bba_pkg::S_SPLIT_RD: state_in = bba_pkg::S_SPLIT_WR;
         bba_pkg::S_SPLIT_WR: begin
            state_in = (k_ff > ord_ff) ? bba_pkg::S_SPLIT_RD : bba_pkg::S_ALLOC_END;
         end
         bba_pkg::S_ALLOC_END: state_in = bba_pkg::S_RESP;
         bba_pkg::S_USED_RD: state_in = bba_pkg::S_USED_CK;
         bba_pkg::S_USED_CK: state_in = used_bad ? bba_pkg::S_RESP : bba_pkg::S_MERGE_RD;
         bba_pkg::S_MERGE_RD: state_in = bba_pkg::S_MERGE_CK;
         bba_pkg::S_MERGE_CK: state_in = merge_go ? bba_pkg::S_MERGE_RD : bba_pkg::S_RESP;
         bba_pkg::S_RESP: begin
            if (rsp_free) begin
               state_in = bba_pkg::S_IDLE;
            end
         end
         default: state_in = bba_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      clr_in = clr_ff;
      req_in = req_ff;
      ord_in = ord_ff;
      k_in = k_ff;
      idx_in = idx_ff;
      u_in = u_ff;
      scan_in = scan_ff;
      scan_vld_in = scan_vld_ff;
      status_in = status_ff;
      granted_in = granted_ff;
      free_blk_in = free_blk_ff;
      free_pay_in = free_pay_ff;
      blk_in = blk_ff;
      pay_in = pay_ff;
      cnt_in = cnt_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall = 1'b1;
      map_we = 1'b0;
      map_waddr = '0;
      map_wdata = '0;
      map_raddr = '0;
      used_we = 1'b0;
      used_waddr = '0;
      used_wdata = '0;
      used_raddr = '0;
      unique case (state_ff)
         bba_pkg::S_CLEAR: begin
            clr_in = clr_ff + 15'd1;
            used_we = 1'b1;
            used_waddr = clr_ff;
            if (clr_ff < 15'(bba_pkg::MAP_WORDS)) begin
               map_we = 1'b1;
               map_waddr = clr_ff[bba_pkg::MAP_ADDR_W-1:0];
               map_wdata = (clr_ff[bba_pkg::MAP_ADDR_W-1:0] == bba_pkg::TOP_WORD_ADDR) ?
                           '1 : '0;
            end
         end
         bba_pkg::S_IDLE: begin
            req_stall = 1'b0;
            req_in = req_data;
         end
         bba_pkg::S_DECODE: begin
            granted_in = 22'd0;
            scan_in = '0;
            scan_vld_in = 1'b0;
            ord_in = dec_ord;
            k_in = dec_kf;
            u_in = free_s[21:7];
            if (req_ff.kind == bba_pkg::KIND_ALLOC) begin
               status_in = dec_refuse ? bba_pkg::STATUS_REFUSED : bba_pkg::STATUS_NO_BLOCK;
            end else begin
               status_in = bba_pkg::STATUS_IGNORED;
            end
         end
         bba_pkg::S_SCAN: begin
            map_raddr = bba_pkg::word_base(k_ff) + {1'b0, scan_ff};
            scan_in = scan_ff + 10'd1;
            scan_vld_in = 1'b1;
            if (scan_hit) begin
               idx_in = {scan_wi, scan_bit};
               u_in = 15'({scan_wi, scan_bit} << k_ff);
               map_we = 1'b1;
               map_waddr = bba_pkg::word_base(k_ff) + {1'b0, scan_wi};
               map_wdata = map_rdata & ~(32'd1 << scan_bit);
               cnt_in[k_ff] = cnt_ff[k_ff] - 16'd1;
               free_blk_in = free_blk_ff - 16'd1;
               free_pay_in = free_pay_ff - k_pay;
               if (k_ff > ord_ff) begin
                  k_in = k_ff - 4'd1;
               end
            end
         end
         bba_pkg::S_SPLIT_RD: begin
            map_raddr = bba_pkg::word_base(k_ff) + {1'b0, split_j[14:5]};
         end
         bba_pkg::S_SPLIT_WR: begin
            map_we = 1'b1;
            map_waddr = bba_pkg::word_base(k_ff) + {1'b0, split_j[14:5]};
            map_wdata = map_rdata | (32'd1 << split_j[4:0]);
            cnt_in[k_ff] = cnt_ff[k_ff] + 16'd1;
            free_blk_in = free_blk_ff + 16'd1;
            free_pay_in = free_pay_ff + k_pay;
            blk_in = blk_ff + 16'd1;
            pay_in = pay_ff - {16'd0, hdr_ff};
            if (k_ff > ord_ff) begin
               k_in = k_ff - 4'd1;
            end
         end
         bba_pkg::S_ALLOC_END: begin
            used_we = 1'b1;
            used_waddr = u_ff;
            used_wdata = ord_ff + 4'd1;
            status_in = bba_pkg::STATUS_DONE;
            granted_in = {u_ff, 7'd0} + {15'd0, hdr_ff};
         end
         bba_pkg::S_USED_RD: begin
            used_raddr = u_ff;
         end
         bba_pkg::S_USED_CK: begin
            if (!used_bad) begin
               k_in = used_rdata - 4'd1;
               idx_in = u_ff >> (used_rdata - 4'd1);
               used_we = 1'b1;
               used_waddr = u_ff;
               used_wdata = 4'd0;
            end
         end
         bba_pkg::S_MERGE_RD: begin
            map_raddr = bba_pkg::word_base(k_ff) + {1'b0, idx_ff[14:5]};
         end
         bba_pkg::S_MERGE_CK: begin
            map_we = 1'b1;
            map_waddr = bba_pkg::word_base(k_ff) + {1'b0, idx_ff[14:5]};
            if (merge_go) begin
               map_wdata = map_rdata & ~(32'd1 << (idx_ff[4:0] ^ 5'd1));
               cnt_in[k_ff] = cnt_ff[k_ff] - 16'd1;
               free_blk_in = free_blk_ff - 16'd1;
               free_pay_in = free_pay_ff - k_pay;
               blk_in = blk_ff - 16'd1;
               pay_in = pay_ff + {16'd0, hdr_ff};
               idx_in = idx_ff >> 1;
               k_in = k_ff + 4'd1;
            end else begin
               map_wdata = map_rdata | (32'd1 << idx_ff[4:0]);
               cnt_in[k_ff] = cnt_ff[k_ff] + 16'd1;
               free_blk_in = free_blk_ff + 16'd1;
               free_pay_in = free_pay_ff + k_pay;
               status_in = bba_pkg::STATUS_DONE;
            end
         end
         bba_pkg::S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.status = status_ff;
               rsp_in.granted_offset = granted_ff;
               rsp_in.free_block_count = free_blk_ff;
               rsp_in.free_payload_bytes = free_pay_ff;
               rsp_in.total_block_count = blk_ff;
               rsp_in.total_payload_bytes = pay_ff;
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bba_pkg::S_CLEAR;
         clr_ff <= '0;
         hdr_ff <= bba_pkg::HEADER_AT_RESET;
         free_blk_ff <= bba_pkg::BLOCKS_AT_RESET;
         blk_ff <= bba_pkg::BLOCKS_AT_RESET;
         free_pay_ff <= bba_pkg::PAYLOAD_AT_RESET;
         pay_ff <= bba_pkg::PAYLOAD_AT_RESET;
         for (int k = 0; k < bba_pkg::ORDER_COUNT; k++) begin
            cnt_ff[k] <= (k == bba_pkg::TOP_ORDER) ? bba_pkg::BLOCKS_AT_RESET : 16'd0;
         end
         rsp_valid_ff <= 1'b0;
         scan_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         if (csr_wr_en) begin
            hdr_ff <= csr_wr_data;
         end
         free_blk_ff <= free_blk_in;
         blk_ff <= blk_in;
         free_pay_ff <= free_pay_in;
         pay_ff <= pay_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_vld_ff <= scan_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      ord_ff <= ord_in;
      k_ff <= k_in;
      idx_ff <= idx_in;
      u_ff <= u_in;
      scan_ff <= scan_in;
      status_ff <= status_in;
      granted_ff <= granted_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

// ===== rtl/core/bba_ram.sv =====
// Simple dual-port synchronous RAM with one write port and one registered read port.
`default_nettype none
module bba_ram #(
   parameter int DATA_W = 32,
   parameter int ADDR_W = 11
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [DATA_W-1:0] wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [0:(1 << ADDR_W) - 1];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

// ===== rtl/core/bba_checker.sv =====
// Port-level assertions for the buddy block allocator, bound to its top level.
`default_nettype none
module bba_checker (
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            req_valid,
   input wire logic            req_stall,
   input wire logic            rsp_valid,
   input wire logic            rsp_stall,
   input wire bba_pkg::rsp_type rsp_data
);

   // A stalled result must hold until its transfer completes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Requests are worked one at a time, so an accepted request stalls the next.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.free_block_count <= rsp_data.total_block_count)
      else $error("more free blocks than blocks");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != bba_pkg::STATUS_DONE) |-> rsp_data.granted_offset == 22'd0)
      else $error("offset given with a failed request");

endmodule

bind buddy_block_allocator_core bba_checker u_bba_checker (.*);
`default_nettype wire

// ===== sim/buddy_block_allocator_checker.sv =====
// Checker for the buddy block allocator: watches both channels, predicts results and compares.
`timescale 1ns / 100ps
module buddy_block_allocator_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_stall,
   input  wire bba_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_stall,
   input  wire bba_pkg::rsp_type rsp_data,
   input  wire logic             csr_wr_en,
   input  wire logic [6:0]       csr_wr_data,
   output int                    fail_count,
   output int                    pending_count
);

   localparam int TOP_COUNT = 32;
   localparam int UNITS = TOP_COUNT << bba_pkg::TOP_ORDER;

   bit free_bits [bba_pkg::ORDER_COUNT][UNITS];
   logic [4:0] used_order [UNITS];
   logic [15:0] blocks_all;
   logic [22:0] payload_all;
   logic [15:0] blocks_free;
   logic [22:0] payload_free;
   logic [6:0] header;
   bba_pkg::rsp_type pending_rsp [$];

   function automatic int blocks_in(int k);
      return TOP_COUNT << (bba_pkg::TOP_ORDER - k);
   endfunction

   function automatic void tally_free(int k, bit add);
      logic [22:0] pay;
      pay = (23'd128 << k) - {16'd0, header};
      if (add) begin
         blocks_free = blocks_free + 16'd1;
         payload_free = payload_free + pay;
      end else begin
         blocks_free = blocks_free - 16'd1;
         payload_free = payload_free - pay;
      end
   endfunction

   function automatic void clear_heap();
      for (int k = 0; k < bba_pkg::ORDER_COUNT; k++)
         for (int i = 0; i < UNITS; i++)
            free_bits[k][i] = (k == bba_pkg::TOP_ORDER) && (i < TOP_COUNT);
      for (int i = 0; i < UNITS; i++)
         used_order[i] = '0;
      header = bba_pkg::HEADER_AT_RESET;
      blocks_all = bba_pkg::BLOCKS_AT_RESET;
      blocks_free = bba_pkg::BLOCKS_AT_RESET;
      payload_all = bba_pkg::PAYLOAD_AT_RESET;
      payload_free = bba_pkg::PAYLOAD_AT_RESET;
   endfunction

   function automatic void grant_block(logic [26:0] size, ref bba_pkg::rsp_type r);
      longint eff;
      int ord, k, idx, u;
      bit found;
      found = 0;
      idx = 0;
      if (size == 0 || size > bba_pkg::SIZE_LIMIT) begin
         r.status = bba_pkg::STATUS_REFUSED;
         return;
      end
      eff = longint'(size) + header;
      if (eff > 131072) begin
         r.status = bba_pkg::STATUS_REFUSED;
         return;
      end
      ord = 0;
      while (ord < bba_pkg::TOP_ORDER && (longint'(128) << ord) < eff)
         ord++;
      for (k = ord; k <= bba_pkg::TOP_ORDER; k++) begin
         for (idx = 0; idx < blocks_in(k); idx++)
            if (free_bits[k][idx]) begin
               found = 1;
               break;
            end
         if (found)
            break;
      end
      if (!found) begin
         r.status = bba_pkg::STATUS_NO_BLOCK;
         return;
      end
      free_bits[k][idx] = 0;
      tally_free(k, 0);
      u = idx << k;
      while (k > ord) begin
         k--;
         free_bits[k][(u >> k) + 1] = 1;
         blocks_all = blocks_all + 16'd1;
         payload_all = payload_all - {16'd0, header};
         tally_free(k, 1);
      end
      used_order[u] = 5'(ord + 1);
      r.status = bba_pkg::STATUS_DONE;
      r.granted_offset = 22'(u * 128 + header);
   endfunction

   function automatic void release_block(logic [21:0] off, ref bba_pkg::rsp_type r);
      int s, u, k, idx;
      r.status = bba_pkg::STATUS_IGNORED;
      if (off < header)
         return;
      s = int'(off) - header;
      if (s % 128 != 0 || s / 128 >= UNITS)
         return;
      u = s / 128;
      if (used_order[u] == 0 || used_order[u] > bba_pkg::TOP_ORDER + 1)
         return;
      k = used_order[u] - 1;
      used_order[u] = '0;
      idx = u >> k;
      while (k < bba_pkg::TOP_ORDER) begin
         if (!free_bits[k][idx ^ 1])
            break;
         free_bits[k][idx ^ 1] = 0;
         tally_free(k, 0);
         blocks_all = blocks_all - 16'd1;
         payload_all = payload_all + {16'd0, header};
         idx = idx >> 1;
         k++;
      end
      free_bits[k][idx] = 1;
      tally_free(k, 1);
      r.status = bba_pkg::STATUS_DONE;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      bba_pkg::rsp_type r, want;
      if (reset) begin
         clear_heap();
         pending_rsp.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
               report_mismatch("unexpected transfer", 32'(rsp_data.status), 32'd0);
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
               if (rsp_data.granted_offset !== want.granted_offset)
                  report_mismatch("granted_offset", 32'(rsp_data.granted_offset),
                                  32'(want.granted_offset));
               if (rsp_data.free_block_count !== want.free_block_count)
                  report_mismatch("free_block_count", 32'(rsp_data.free_block_count),
                                  32'(want.free_block_count));
               if (rsp_data.free_payload_bytes !== want.free_payload_bytes)
                  report_mismatch("free_payload_bytes", 32'(rsp_data.free_payload_bytes),
                                  32'(want.free_payload_bytes));
               if (rsp_data.total_block_count !== want.total_block_count)
                  report_mismatch("total_block_count", 32'(rsp_data.total_block_count),
                                  32'(want.total_block_count));
               if (rsp_data.total_payload_bytes !== want.total_payload_bytes)
                  report_mismatch("total_payload_bytes", 32'(rsp_data.total_payload_bytes),
                                  32'(want.total_payload_bytes));
            end
         end
         if (req_valid && !req_stall) begin
            r = '0;
            if (req_data.kind == bba_pkg::KIND_ALLOC)
               grant_block(req_data.request_size, r);
            else
               release_block(req_data.payload_offset, r);
            r.free_block_count = blocks_free;
            r.free_payload_bytes = payload_free;
            r.total_block_count = blocks_all;
            r.total_payload_bytes = payload_all;
            pending_rsp.push_back(r);
         end
         if (csr_wr_en)
            header = csr_wr_data;
      end
      pending_count = pending_rsp.size();
   end

endmodule

// ===== sim/buddy_block_allocator_core_tb.sv =====
// Testbench top for the buddy block allocator: stimulus, idling, pressure and verdict.
`timescale 1ns / 100ps
module buddy_block_allocator_core_tb;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   bba_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   bba_pkg::rsp_type rsp_data;
   logic csr_wr_en;
   logic [6:0] csr_wr_data;
   int fail_count;
   int pending_count;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_cycles;
   logic hold_req;
   logic hold_taken;
   int cycle_count;
   logic [21:0] live_offsets [$];

   buddy_block_allocator_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   buddy_block_allocator_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 10000000) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // The receiver stalls at random, or solidly while a hold-off is counted down.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_cycles <= 0;
         hold_taken <= 1'b0;
      end else if (hold_req && !hold_taken) begin
         rsp_stall <= 1'b1;
         hold_cycles <= 400;
         hold_taken <= 1'b1;
      end else if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Grants are snooped so that frees can name live blocks.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall && rsp_data.status == bba_pkg::STATUS_DONE
          && rsp_data.granted_offset != 0)
         live_offsets.push_back(rsp_data.granted_offset);
   end

   task automatic send_item(bba_pkg::req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do
         @(posedge clock);
      while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_alloc(logic [26:0] size);
      bba_pkg::req_type item;
      item = '0;
      item.kind = bba_pkg::KIND_ALLOC;
      item.request_size = size;
      item.payload_offset = 22'($urandom);
      send_item(item);
   endtask

   task automatic send_free(logic [21:0] off);
      bba_pkg::req_type item;
      item = '0;
      item.kind = bba_pkg::KIND_FREE;
      item.payload_offset = off;
      item.request_size = 27'($urandom);
      send_item(item);
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (2200) @(negedge clock);
   endtask

   task automatic write_header(logic [6:0] value);
      drain_all();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [26:0] pick_size();
      int r;
      r = $urandom_range(99);
      if (r < 55)
         return 27'($urandom_range(1, 600));
      else if (r < 85)
         return 27'($urandom_range(1, 16000));
      else if (r < 93)
         return 27'($urandom_range(16000, 131072));
      else if (r < 97)
         return 27'($urandom_range(131000, 100000001));
      return 27'($urandom);
   endfunction

   task automatic random_phase(int count);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 50)
            send_alloc(pick_size());
         else if (pick < 88 && live_offsets.size() > 0) begin
            int j;
            j = $urandom_range(live_offsets.size() - 1);
            send_free(live_offsets[j]);
            live_offsets.delete(j);
         end else if (pick < 94)
            send_free(22'($urandom));
         else
            send_free(22'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      hold_req = 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_alloc(27'd0);
      send_alloc(27'd100000001);
      send_alloc(27'h7FFFFFF);
      send_alloc(27'd131072 - 27'd32 + 27'd1);
      send_alloc(27'd131072 - 27'd32);
      send_alloc(27'd1);
      send_alloc(27'd96);
      send_alloc(27'd97);
      send_alloc(27'd100000000);
      send_free(22'd0);
      send_free(22'd33);
      send_free(22'h3FFFFF);
      send_free(22'd32);
      send_free(22'd32);
      drain_all();
      live_offsets.delete();
      for (int i = 0; i < 32; i++)
         send_alloc(27'd131040);
      send_alloc(27'd1);
      send_alloc(27'd5000);
      drain_all();
      for (int i = 0; i < 32; i++)
         send_free(22'(i * 131072 + 32));
      drain_all();
      live_offsets.delete();

      send_idle_pct = 11;
      recv_idle_pct = 50;
      write_header(7'd0);
      random_phase(300);
      write_header(7'd127);
      random_phase(300);
      send_idle_pct = 50;
      recv_idle_pct = 11;
      write_header(7'd64);
      hold_req = 1'b1;
      random_phase(300);
      write_header(7'h55);
      random_phase(300);
      write_header(7'h2A);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(300);
      write_header(7'd32);
      random_phase(300);

      drain_all();
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/bba_pkg.sv
rtl/core/bba_ram.sv
rtl/core/buddy_block_allocator_core.sv
rtl/core/bba_checker.sv
sim/buddy_block_allocator_checker.sv
sim/buddy_block_allocator_core_tb.sv
